[hw/rtl/p2r_pkg.sv]
// shared types, constants and helpers for the planar 2bpp tile-to-raster converter
package p2r_pkg;

  // tile geometry and field widths
  localparam int unsigned TILE_PIXELS = 8;
  localparam int unsigned PIX_W       = 3;   // pixel position inside a tile row
  localparam int unsigned COORD_W     = 9;   // raster coordinate width
  localparam int unsigned DIM_W       = 9;   // clamped grid dimension, holds up to 511
  localparam int unsigned DIM_REG_W   = 7;   // width/height register width
  localparam int unsigned LIMIT_W     = 12;  // tile limit and tile counter width
  localparam int unsigned PLANE_W     = 8;
  localparam int unsigned GRAY_W      = 8;
  localparam int unsigned INDEX_W     = 2;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // default grid maxima
  localparam int unsigned MAX_TILES_ACROSS_DEF = 64;
  localparam int unsigned MAX_TILES_DOWN_DEF   = 64;

  localparam logic [PIX_W-1:0]   PIX_LAST  = PIX_W'(TILE_PIXELS - 1);
  localparam logic [LIMIT_W-1:0] COUNT_MAX = {LIMIT_W{1'b1}};

  // register map
  localparam logic [CFG_ADDR_W-1:0] REG_TILES_PER_ROW    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TILES_PER_COLUMN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TILE_LIMIT       = 2'd2;

  // reset values of the registers
  localparam logic [DIM_REG_W-1:0] TILES_PER_ROW_RST    = 7'd64;
  localparam logic [DIM_REG_W-1:0] TILES_PER_COLUMN_RST = 7'd64;
  localparam logic [LIMIT_W-1:0]   TILE_LIMIT_RST       = 12'd0;

  // palette indexes
  localparam logic [INDEX_W-1:0] IDX_WHITE = 2'd0;
  localparam logic [INDEX_W-1:0] IDX_LIGHT = 2'd1;
  localparam logic [INDEX_W-1:0] IDX_DARK  = 2'd2;

  // one placed tile row handed to the pixel serializer
  typedef struct packed {
    logic [PLANE_W-1:0] low_plane;
    logic [PLANE_W-1:0] high_plane;
    logic [5:0]         x_tile;    // tile column, folded to the 9-bit raster
    logic [COORD_W-1:0] y;         // raster row of this tile row
    logic               last_row;  // eighth row of the tile
  } row_t;

  // zero acts as one, above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_REG_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (ext > maxv) begin
      return maxv;
    end
    return ext;
  endfunction

  function automatic logic [GRAY_W-1:0] gray_of(logic [INDEX_W-1:0] idx);
    case (idx)
      IDX_WHITE: return 8'd255;
      IDX_LIGHT: return 8'd200;
      IDX_DARK:  return 8'd100;
      default:   return 8'd0;
    endcase
  endfunction

endpackage

[hw/rtl/p2r_place.sv]
// tile placement: config registers, grid position state, drop and halt decisions
module p2r_place #(
  parameter int unsigned MAX_TILES_ACROSS = p2r_pkg::MAX_TILES_ACROSS_DEF,
  parameter int unsigned MAX_TILES_DOWN   = p2r_pkg::MAX_TILES_DOWN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [p2r_pkg::CFG_ADDR_W-1:0]  cfg_index_i,
  input  logic [p2r_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            accept_i,
  input  logic [p2r_pkg::PLANE_W-1:0]     low_plane_i,
  input  logic [p2r_pkg::PLANE_W-1:0]     high_plane_i,
  output logic                            emit_o,
  output p2r_pkg::row_t                   row_o
);
  import p2r_pkg::*;

  localparam int unsigned COL_W = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int unsigned ROW_W = $clog2(MAX_TILES_DOWN + 1);
  localparam logic [DIM_W-1:0] MAX_ACROSS = DIM_W'(MAX_TILES_ACROSS);
  localparam logic [DIM_W-1:0] MAX_DOWN   = DIM_W'(MAX_TILES_DOWN);

  logic [DIM_REG_W-1:0] tpr_q, tpc_q;
  logic [LIMIT_W-1:0]   limit_q, count_q, count_d;
  logic [PIX_W-1:0]     rit_q, rit_d;
  logic [COL_W-1:0]     col_q, col_d, col0;
  logic [ROW_W-1:0]     row_q, row_d, row0;
  logic                 halted_q, halted_d;

  logic [DIM_W-1:0]     width, height, col1, row0_ext;
  logic [LIMIT_W-1:0]   count_inc;
  logic                 col_wrap, last_row, halt_now;

  always_comb begin
    width    = clamp_dim(tpr_q, MAX_ACROSS);
    height   = clamp_dim(tpc_q, MAX_DOWN);

    // wrap first if the width shrank under the current column
    col_wrap = DIM_W'(col_q) >= width;
    col0     = col_wrap ? '0 : col_q;
    row0     = (col_wrap && (DIM_W'(row_q) < MAX_DOWN)) ? row_q + ROW_W'(1) : row_q;
    row0_ext = DIM_W'(row0);

    emit_o   = !halted_q && (row0_ext < height);
    last_row = rit_q == PIX_LAST;

    count_inc = (count_q == COUNT_MAX) ? count_q : count_q + LIMIT_W'(1);
    halt_now  = (limit_q != '0) && (count_inc >= limit_q);
    col1      = DIM_W'(col0) + DIM_W'(1);

    rit_d    = rit_q;
    col_d    = col_q;
    row_d    = row_q;
    count_d  = count_q;
    halted_d = halted_q;

    if (accept_i && !halted_q) begin
      col_d = col0;
      row_d = row0;
      if (emit_o) begin
        if (!last_row) begin
          rit_d = rit_q + PIX_W'(1);
        end else begin
          rit_d   = '0;
          count_d = count_inc;
          if (halt_now) begin
            halted_d = 1'b1;
          end else if (col1 >= width) begin
            col_d = '0;
            if (row0_ext < MAX_DOWN) begin
              row_d = row0 + ROW_W'(1);
            end
          end else begin
            col_d = col1[COL_W-1:0];
          end
        end
      end
    end

    row_o.low_plane  = low_plane_i;
    row_o.high_plane = high_plane_i;
    row_o.x_tile     = 6'(DIM_W'(col0));
    row_o.y          = {row0_ext[5:0], rit_q};
    row_o.last_row   = last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q    <= TILES_PER_ROW_RST;
      tpc_q    <= TILES_PER_COLUMN_RST;
      limit_q  <= TILE_LIMIT_RST;
      rit_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_TILES_PER_ROW:    tpr_q   <= cfg_data_i[DIM_REG_W-1:0];
          REG_TILES_PER_COLUMN: tpc_q   <= cfg_data_i[DIM_REG_W-1:0];
          REG_TILE_LIMIT:       limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      rit_q    <= rit_d;
      col_q    <= col_d;
      row_q    <= row_d;
      count_q  <= count_d;
      halted_q <= halted_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_halt_on_tile_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (rit_q == '0))
    else $error("halted in the middle of a tile");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q >= $past(count_q)))
    else $error("tile counter went backwards");
`endif

endmodule

[hw/rtl/p2r_serial.sv]
// pixel serializer: holds one placed tile row and sends its eight pixels
module p2r_serial (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  p2r_pkg::row_t                 row_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [p2r_pkg::COORD_W-1:0]   pixel_x_o,
  output logic [p2r_pkg::COORD_W-1:0]   pixel_y_o,
  output logic [p2r_pkg::INDEX_W-1:0]   color_index_o,
  output logic [p2r_pkg::GRAY_W-1:0]    gray_level_o,
  output logic                          row_end_o,
  output logic                          tile_end_o
);
  import p2r_pkg::*;

  logic               busy_q;
  logic [PIX_W-1:0]   pix_q;
  logic [PLANE_W-1:0] low_q, high_q;
  logic [5:0]         x_tile_q;
  logic [COORD_W-1:0] y_q;
  logic               last_row_q;
  logic               last_pix, xfer;

  assign last_pix = pix_q == PIX_LAST;
  assign xfer     = busy_q && out_ready_i;
  assign free_o   = !busy_q || (xfer && last_pix);

  assign out_valid_o   = busy_q;
  assign pixel_x_o     = {x_tile_q, pix_q};
  assign pixel_y_o     = y_q;
  assign color_index_o = {high_q[PLANE_W-1], low_q[PLANE_W-1]};
  assign gray_level_o  = gray_of(color_index_o);
  assign row_end_o     = last_pix;
  assign tile_end_o    = last_pix && last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pix_q  <= '0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        pix_q  <= '0;
      end else if (xfer) begin
        if (last_pix) begin
          busy_q <= 1'b0;
        end
        pix_q <= pix_q + PIX_W'(1);
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      low_q      <= row_i.low_plane;
      high_q     <= row_i.high_plane;
      x_tile_q   <= row_i.x_tile;
      y_q        <= row_i.y;
      last_row_q <= row_i.last_row;
    end else if (xfer) begin
      low_q  <= low_q << 1;
      high_q <= high_q << 1;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (out_ready_i && last_pix)))
    else $error("row loaded over pixels still pending");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_ready_i) |=> (busy_q && $stable(pix_q)))
    else $error("pixel position moved without a transfer");
`endif

endmodule

[hw/rtl/planar_2bpp_tile_to_raster.sv]
// top level of the planar 2bpp tile-row to raster pixel converter
//
// Each input transfer carries one eight-pixel row of an 8x8 tile as a low and
// a high bit-plane byte. The block places the row on a tile grid (left to
// right, wrapping after tiles_per_row tiles) and sends eight pixel transfers,
// leftmost pixel first, each with raster x/y, 2-bit color index, gray level
// (255, 200, 100, 0) and row/tile end flags. One pixel leaves per cycle while
// out_ready_i is high; the pixel serializer takes the next row in the same
// cycle its eighth pixel is transferred, so rows stream with no bubble. Rows
// past the grid height or after tile_limit tiles (0 = no limit) are taken as
// soon as the serializer is free and produce no pixels; once the limit is hit
// the block drops everything until reset. Width and height registers treat 0
// as 1 and clamp to the grid maxima. Config writes are always taken
// (cfg_ready_o is tied high) and must only happen while idle.
module planar_2bpp_tile_to_raster #(
  parameter int unsigned MAX_TILES_ACROSS = p2r_pkg::MAX_TILES_ACROSS_DEF,
  parameter int unsigned MAX_TILES_DOWN   = p2r_pkg::MAX_TILES_DOWN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [p2r_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [p2r_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // tile row input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [p2r_pkg::PLANE_W-1:0]    low_plane_i,
  input  logic [p2r_pkg::PLANE_W-1:0]    high_plane_i,
  // pixel output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [p2r_pkg::COORD_W-1:0]    pixel_x_o,
  output logic [p2r_pkg::COORD_W-1:0]    pixel_y_o,
  output logic [p2r_pkg::INDEX_W-1:0]    color_index_o,
  output logic [p2r_pkg::GRAY_W-1:0]     gray_level_o,
  output logic                           row_end_o,
  output logic                           tile_end_o
);
  import p2r_pkg::*;

  row_t row;
  logic emit, accept, free;

  assign cfg_ready_o = 1'b1;
  // the serializer register is free or frees up in this cycle
  assign in_ready_o  = free;
  assign accept      = in_valid_i && in_ready_o;

  // placement state advances on every accepted row until the tile limit halts it
  p2r_place #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_place (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .low_plane_i  (low_plane_i),
    .high_plane_i (high_plane_i),
    .emit_o       (emit),
    .row_o        (row)
  );

  // dropped rows never reach the serializer
  p2r_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && emit),
    .row_i         (row),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .color_index_o (color_index_o),
    .gray_level_o  (gray_level_o),
    .row_end_o     (row_end_o),
    .tile_end_o    (tile_end_o)
  );

`ifndef NO_ASSERTIONS
  a_tile_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tile_end_o) |-> row_end_o)
    else $error("tile end flagged off a row end");

  a_row_end_on_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && row_end_o) |-> (pixel_x_o[PIX_W-1:0] == PIX_LAST))
    else $error("row end flagged before the eighth pixel");
`endif

endmodule

[sim/planar_2bpp_tile_to_raster_checker.sv]
// pixel stream checker: row placement predictor and in-order compare
`timescale 1ns / 1ps
module planar_2bpp_tile_to_raster_checker #(
  parameter int unsigned GRID_ACROSS = p2r_pkg::MAX_TILES_ACROSS_DEF,
  parameter int unsigned GRID_DOWN   = p2r_pkg::MAX_TILES_DOWN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [p2r_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [p2r_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [p2r_pkg::PLANE_W-1:0]    low_plane_i,
  input  logic [p2r_pkg::PLANE_W-1:0]    high_plane_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [p2r_pkg::COORD_W-1:0]    pixel_x_i,
  input  logic [p2r_pkg::COORD_W-1:0]    pixel_y_i,
  input  logic [p2r_pkg::INDEX_W-1:0]    color_index_i,
  input  logic [p2r_pkg::GRAY_W-1:0]     gray_level_i,
  input  logic                           row_end_i,
  input  logic                           tile_end_i,
  output int                             pending_o,
  output int                             placed_rows_o,
  output int                             errors_o
);
  import p2r_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] idx;
    logic [GRAY_W-1:0]  gray;
    logic               row_end;
    logic               tile_end;
  } pixel_t;

  // gray per palette index, index 0 in the low byte
  localparam logic [31:0] SHADES = {8'd0, 8'd100, 8'd200, 8'd255};

  logic [DIM_REG_W-1:0] across_q;
  logic [DIM_REG_W-1:0] down_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [PIX_W-1:0]     row_in_tile;
  int unsigned          tile_col;
  int unsigned          tile_row;
  int unsigned          tiles_done;
  bit                   halted;
  pixel_t               pending_pixels[$];
  int                   mismatches;
  int                   placed;

  function automatic int unsigned eff_dim(logic [DIM_REG_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  // place one tile row on the grid and queue its eight pixels, unless halted or past the grid height
  task automatic place_row(input logic [PLANE_W-1:0] lo, input logic [PLANE_W-1:0] hi);
    int unsigned  across;
    int unsigned  down;
    int           i;
    logic         last;
    logic [1:0]   idx;
    pixel_t       p;
    across = eff_dim(across_q, GRID_ACROSS);
    down   = eff_dim(down_q, GRID_DOWN);
    if (halted) return;
    if (tile_col >= across) begin
      tile_col = 0;
      if (tile_row < GRID_DOWN) tile_row++;
    end
    if (tile_row >= down) return;
    last = (row_in_tile == PIX_LAST);
    for (i = 0; i < TILE_PIXELS; i++) begin
      idx        = {hi[7-i], lo[7-i]};
      p.x        = COORD_W'(tile_col * TILE_PIXELS + i);
      p.y        = COORD_W'(tile_row * TILE_PIXELS + row_in_tile);
      p.idx      = idx;
      p.gray     = SHADES[idx*8 +: 8];
      p.row_end  = (i == TILE_PIXELS - 1);
      p.tile_end = (i == TILE_PIXELS - 1) && last;
      pending_pixels.push_back(p);
    end
    placed++;
    if (!last) begin
      row_in_tile++;
    end else begin
      row_in_tile = '0;
      if (tiles_done < COUNT_MAX) tiles_done++;
      if (limit_q != '0 && tiles_done >= limit_q) begin
        halted = 1'b1;
      end else begin
        tile_col++;
        if (tile_col >= across) begin
          tile_col = 0;
          if (tile_row < GRID_DOWN) tile_row++;
        end
      end
    end
  endtask

  task automatic report(input string what, input pixel_t want, input pixel_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected x=%0d y=%0d idx=%0d gray=%0d row_end=%0b tile_end=%0b",
               what, want.x, want.y, want.idx, want.gray, want.row_end, want.tile_end);
      $display("  got x=%0d y=%0d idx=%0d gray=%0d row_end=%0b tile_end=%0b",
               got.x, got.y, got.idx, got.gray, got.row_end, got.tile_end);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      across_q    = TILES_PER_ROW_RST;
      down_q      = TILES_PER_COLUMN_RST;
      limit_q     = TILE_LIMIT_RST;
      row_in_tile = '0;
      tile_col    = 0;
      tile_row    = 0;
      tiles_done  = 0;
      halted      = 1'b0;
      pending_pixels.delete();
      mismatches  = 0;
      placed      = 0;
      pending_o     <= 0;
      placed_rows_o <= 0;
      errors_o      <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.x        = pixel_x_i;
        got.y        = pixel_y_i;
        got.idx      = color_index_i;
        got.gray     = gray_level_i;
        got.row_end  = row_end_i;
        got.tile_end = tile_end_i;
        if (pending_pixels.size() == 0) begin
          report("pixel with nothing pending", '0, got);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) report("pixel mismatch", want, got);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TILES_PER_ROW:    across_q = cfg_data_i[DIM_REG_W-1:0];
          REG_TILES_PER_COLUMN: down_q   = cfg_data_i[DIM_REG_W-1:0];
          REG_TILE_LIMIT:       limit_q  = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) place_row(low_plane_i, high_plane_i);
      pending_o     <= pending_pixels.size();
      placed_rows_o <= placed;
      errors_o      <= mismatches;
    end
  end

endmodule

[sim/planar_2bpp_tile_to_raster_tb.sv]
// testbench top: stimulus, flow control and verdict for the tile-to-raster converter
`timescale 1ns / 1ps
module planar_2bpp_tile_to_raster_tb;
  import p2r_pkg::*;

  localparam int unsigned RANDOM_ROWS   = 130;
  localparam int unsigned SETTLE_CYCLES = 32;      // settle time after the pixel queue empties
  localparam int unsigned CYCLE_LIMIT   = 500000;  // far above the slowest legal run
  // index outside the register map, writes to it must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [PLANE_W-1:0]    low_plane = '0;
  logic [PLANE_W-1:0]    high_plane = '0;
  logic                  out_ready = 1'b0;

  logic                  cfg_ready;
  logic                  in_ready;
  logic                  out_valid;
  logic [COORD_W-1:0]    pixel_x;
  logic [COORD_W-1:0]    pixel_y;
  logic [INDEX_W-1:0]    color_index;
  logic [GRAY_W-1:0]     gray_level;
  logic                  row_end;
  logic                  tile_end;

  int                    pending;
  int                    placed;
  int                    errors;
  int unsigned           cycles = 0;

  // idle chances in percent, changed per phase of the run
  int unsigned           send_idle = 32;
  int unsigned           recv_idle = 79;

  planar_2bpp_tile_to_raster dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .low_plane_i   (low_plane),
    .high_plane_i  (high_plane),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .color_index_o (color_index),
    .gray_level_o  (gray_level),
    .row_end_o     (row_end),
    .tile_end_o    (tile_end)
  );

  planar_2bpp_tile_to_raster_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .low_plane_i   (low_plane),
    .high_plane_i  (high_plane),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .color_index_i (color_index),
    .gray_level_i  (gray_level),
    .row_end_i     (row_end),
    .tile_end_i    (tile_end),
    .pending_o     (pending),
    .placed_rows_o (placed),
    .errors_o      (errors)
  );

  always #1 clk = ~clk;

  // pixel side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("planar_2bpp_tile_to_raster_tb: errors");
      $finish;
    end
  end

  // mostly random bytes, with all-zero and all-one planes now and then
  function automatic logic [PLANE_W-1:0] rand_plane();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PLANE_W'($urandom);
    endcase
  endfunction

  // grid dimension for a register write: zero, small, the max, oversize or anything,
  // with junk in the bits above the register width
  function automatic logic [CFG_DATA_W-1:0] rand_dim();
    logic [DIM_REG_W-1:0] d;
    case ($urandom_range(7))
      0:       d = '0;
      1, 2, 3: d = DIM_REG_W'($urandom_range(6, 1));
      4:       d = DIM_REG_W'(64);
      5, 6:    d = '1;
      default: d = DIM_REG_W'($urandom_range(127, 1));
    endcase
    return {5'($urandom), d};
  endfunction

  // one row transfer, with random sender gaps in front of it
  task automatic send_row(input logic [PLANE_W-1:0] lo, input logic [PLANE_W-1:0] hi);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    low_plane  <= lo;
    high_plane <= hi;
    do @(posedge clk); while (!in_ready);
  endtask

  // register write, with cfg_valid dropped again before the task returns
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every queued pixel has come out
  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // full idle: queue empty plus time for a dropped row still inside the block
  task automatic drain();
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned base;
    int unsigned target;
    int unsigned rows;
    int unsigned pause_at;
    int unsigned k;
    bit          first;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first tile at reset settings: every index in every pixel position
    send_row(8'h00, 8'h00);
    send_row(8'hFF, 8'h00);
    send_row(8'h00, 8'hFF);
    send_row(8'hFF, 8'hFF);
    send_row(8'hAA, 8'h55);
    send_row(8'h55, 8'hAA);
    send_row(8'h0F, 8'hF0);
    send_row(8'hC3, 8'h3C);
    drain();

    // zero width acts as one, and the column left over from the last tile
    // is past it, so the next row wraps first; oversize height clamps
    write_reg(REG_TILES_PER_ROW, 12'h000);
    write_reg(REG_UNMAPPED, 12'hFFF);
    write_reg(REG_TILES_PER_COLUMN, 12'h07F);
    for (k = 0; k < 8; k++) send_row(rand_plane(), rand_plane());
    drain();

    // grid full: rows go nowhere until the height is raised again
    write_reg(REG_TILES_PER_COLUMN, 12'h001);
    send_row(8'hFF, 8'h81);
    send_row(8'h7E, 8'h00);
    drain();
    write_reg(REG_TILES_PER_COLUMN, 12'hFFF);
    write_reg(REG_TILES_PER_ROW, 12'h07F);
    write_reg(REG_TILE_LIMIT, 12'hFFF);
    for (k = 0; k < 4; k++) send_row(rand_plane(), rand_plane());
    drain();

    // random segments with fresh geometry each time, runs of rows that
    // cross tile and segment boundaries
    base   = placed;
    target = base + RANDOM_ROWS;
    first  = 1'b1;
    while (placed < target) begin
      if (placed - base >= 2 * RANDOM_ROWS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (placed - base >= RANDOM_ROWS / 3) begin
        send_idle = 79;
        recv_idle = 32;
      end
      drain();
      write_reg(REG_TILES_PER_ROW, rand_dim());
      write_reg(REG_TILES_PER_COLUMN, rand_dim());
      // limits that never trip here: none, or beyond what the run converts
      if ($urandom_range(3) == 0) write_reg(REG_TILE_LIMIT, $urandom_range(1) ? 12'hFFF : 12'h000);
      rows     = $urandom_range(24, 1);
      pause_at = (first || $urandom_range(3) == 0) ? $urandom_range(rows - 1) : rows;
      for (k = 0; k < rows; k++) begin
        if (k == pause_at) wait_empty();
        send_row(rand_plane(), rand_plane());
      end
      first = 1'b0;
    end
    drain();

    // tile limit: the next finished tile halts the block for good,
    // and clearing the limit afterwards must not wake it
    write_reg(REG_TILES_PER_COLUMN, 12'h07F);
    write_reg(REG_TILE_LIMIT, 12'h001);
    for (k = 0; k < 12; k++) send_row(rand_plane(), rand_plane());
    drain();
    write_reg(REG_TILE_LIMIT, 12'h000);
    for (k = 0; k < 4; k++) send_row(rand_plane(), rand_plane());
    drain();

    if (errors == 0) begin
      $display("planar_2bpp_tile_to_raster_tb: clean");
    end else begin
      $display("planar_2bpp_tile_to_raster_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/p2r_pkg.sv
hw/rtl/p2r_place.sv
hw/rtl/p2r_serial.sv
hw/rtl/planar_2bpp_tile_to_raster.sv
sim/planar_2bpp_tile_to_raster_checker.sv
sim/planar_2bpp_tile_to_raster_tb.sv
